[hdl/firmware_signature_classifier_unit_assert.svh]
// Assertion macros shared by the checker of the firmware signature classifier.
// No dependencies; include by bare file name.
`ifndef FIRMWARE_SIGNATURE_CLASSIFIER_UNIT_ASSERT_SVH
`define FIRMWARE_SIGNATURE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsc assertion failed");

`endif

[hdl/fsc_pkg.sv]
// Types, constants and lookup functions of the firmware signature classifier.
// No dependencies.
package fsc_pkg;

    localparam int COUNT_W              = 24;
    localparam int STARTUP_BYTES        = 1024;
    localparam int SIGNATURE_SIZE_LIMIT = 130048;
    localparam int START_WORD_LAST_IDX  = 7;
    localparam int SIG_MIN_SIZE         = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [2:0]         t_family;
    typedef logic [1:0]         t_sig;
    typedef logic [3:0]         t_model;

    localparam t_family FAM_NONE = 3'd0;
    localparam t_family FAM_F9   = 3'd1;
    localparam t_family FAM_1BD  = 3'd2;
    localparam t_family FAM_C1   = 3'd3;
    localparam t_family FAM_199  = 3'd4;
    localparam t_family FAM_1D1  = 3'd5;

    localparam t_sig SIG_NONE = 2'd0;
    localparam t_sig SIG_7E   = 2'd1;
    localparam t_sig SIG_3F   = 2'd2;
    localparam t_sig SIG_FE   = 2'd3;

    localparam t_model MODEL_NONE     = 4'd0;
    localparam t_model MODEL_F9       = 4'd1;
    localparam t_model MODEL_1BD      = 4'd2;
    localparam t_model MODEL_PAIRED   = 4'd3;
    localparam t_model MODEL_C1       = 4'd4;
    localparam t_model MODEL_199      = 4'd5;
    localparam t_model MODEL_1D1      = 4'd6;
    localparam t_model MODEL_SIG_BASE = 4'd6;

    localparam logic [31:0] WORD_F9  = 32'h0000_00F9;
    localparam logic [31:0] WORD_1BD = 32'h0000_01BD;
    localparam logic [31:0] WORD_C1  = 32'h0000_00C1;
    localparam logic [31:0] WORD_199 = 32'h0000_0199;
    localparam logic [31:0] WORD_1D1 = 32'h0000_01D1;

    localparam logic [31:0] MAGIC_WIDE  = 32'h0004_3F82;
    localparam logic [31:0] MAGIC_SHORT = 32'h0000_3F82;

    localparam logic [63:0] SIGNATURE_7E = 64'h94F8_CFFF_7E00_940C;
    localparam logic [63:0] SIGNATURE_3F = 64'h94F8_CFFF_3F00_940C;
    localparam logic [63:0] SIGNATURE_FE = 64'h94F8_CFFF_FE00_940C;

    localparam logic [1:0] GUESS_LIMIT_RESET = 2'd2;
    localparam logic [1:0] GUESS_LIMIT_PAIR  = 2'd2;

    typedef struct packed {
        t_count  size;
        t_family family;
        logic    magic;
        t_sig    sig;
    } t_scan_status;

    typedef struct packed {
        logic [1:0] count;
        t_model     first;
        t_model     second;
    } t_result;

    function automatic t_family family_of(input logic [31:0] w);
        t_family f;
        case (w)
            WORD_F9:  f = FAM_F9;
            WORD_1BD: f = FAM_1BD;
            WORD_C1:  f = FAM_C1;
            WORD_199: f = FAM_199;
            WORD_1D1: f = FAM_1D1;
            default:  f = FAM_NONE;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] magic_of(input t_family f);
        return (f == FAM_C1) ? MAGIC_SHORT : MAGIC_WIDE;
    endfunction

    function automatic t_model model_of(input t_family f);
        t_model m;
        case (f)
            FAM_F9:  m = MODEL_F9;
            FAM_1BD: m = MODEL_1BD;
            FAM_C1:  m = MODEL_C1;
            FAM_199: m = MODEL_199;
            default: m = MODEL_1D1;
        endcase
        return m;
    endfunction

    function automatic t_sig sig_of(input logic [63:0] w);
        t_sig s;
        case (w)
            SIGNATURE_7E: s = SIG_7E;
            SIGNATURE_3F: s = SIG_3F;
            SIGNATURE_FE: s = SIG_FE;
            default:      s = SIG_NONE;
        endcase
        return s;
    endfunction

endpackage

[hdl/fsc_scan.sv]
// Per-byte scan state: byte count, sliding window, start word, family, magic and signature hits.
// Depends on fsc_pkg.
module fsc_scan
    import fsc_pkg::*;
#(
    parameter int STARTUP_SIZE = STARTUP_BYTES
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_scan_status o_status
);

    t_count      r_count,      n_count;
    logic [55:0] r_recent;
    logic [31:0] r_start_word, n_start_word;
    t_family     r_family,     n_family;
    logic        r_magic,      n_magic;
    t_sig        r_sig,        n_sig;

    logic [63:0] win8;
    logic [31:0] win4;
    t_count      start;
    logic        magic_hit;

    always_comb begin
        win8  = {i_byte, r_recent};
        win4  = win8[63:32];
        start = r_count - t_count'(3);

        n_count = (r_count == COUNT_MAX) ? r_count : r_count + t_count'(1);

        if (r_count == t_count'(START_WORD_LAST_IDX)) begin
            n_start_word = win4;
            n_family     = family_of(win4);
        end else begin
            n_start_word = r_start_word;
            n_family     = r_family;
        end

        // window must start at or after the start word and end before the startup limit
        magic_hit = (r_count > t_count'(START_WORD_LAST_IDX)) && (r_family != FAM_NONE)
                 && ({8'd0, start} >= r_start_word)
                 && (start < t_count'(STARTUP_SIZE - 4))
                 && (win4 == magic_of(r_family));
        n_magic = r_magic | magic_hit;

        // the window closing on the last byte is never checked
        if ((r_count >= t_count'(START_WORD_LAST_IDX)) && !i_last && (r_sig == SIG_NONE)) begin
            n_sig = sig_of(win8);
        end else begin
            n_sig = r_sig;
        end

        o_status.size   = n_count;
        o_status.family = n_family;
        o_status.magic  = n_magic;
        o_status.sig    = n_sig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count      <= '0;
            r_recent     <= '0;
            r_start_word <= '0;
            r_family     <= FAM_NONE;
            r_magic      <= 1'b0;
            r_sig        <= SIG_NONE;
        end else if (i_step) begin
            r_count      <= n_count;
            r_recent     <= win8[63:8];
            r_start_word <= n_start_word;
            r_family     <= n_family;
            r_magic      <= n_magic;
            r_sig        <= n_sig;
        end
    end

endmodule

[hdl/fsc_decide.sv]
// Final model decision from the scan status at the last byte of an image.
// Depends on fsc_pkg.
module fsc_decide
    import fsc_pkg::*;
#(
    parameter int STARTUP_SIZE   = STARTUP_BYTES,
    parameter int SIG_SIZE_LIMIT = SIGNATURE_SIZE_LIMIT
)
(
    input  t_scan_status i_status,
    input  logic [1:0]   i_guess_limit,
    output t_result      o_result
);

    logic word_ok;
    logic sig_ok;

    always_comb begin
        word_ok = (i_status.size >= t_count'(STARTUP_SIZE))
               && (i_status.family != FAM_NONE) && i_status.magic;
        sig_ok  = (i_status.size > t_count'(SIG_MIN_SIZE))
               && (i_status.size <= t_count'(SIG_SIZE_LIMIT))
               && (i_status.sig != SIG_NONE);

        o_result.count  = 2'd0;
        o_result.first  = MODEL_NONE;
        o_result.second = MODEL_NONE;
        if (word_ok) begin
            o_result.count = 2'd1;
            o_result.first = model_of(i_status.family);
            if ((i_status.family == FAM_1BD) && (i_guess_limit >= GUESS_LIMIT_PAIR)) begin
                o_result.count  = 2'd2;
                o_result.second = MODEL_PAIRED;
            end
        end else if (sig_ok) begin
            o_result.count = 2'd1;
            o_result.first = MODEL_SIG_BASE + {2'd0, i_status.sig};
        end
    end

endmodule

[hdl/firmware_signature_classifier_unit.sv]
// Firmware signature classifier: top level with input register, scan, decision, result.
// Depends on fsc_pkg, fsc_scan and fsc_decide.
//
// Usage:
//   Stream a firmware image one byte per beat on i_image_byte, in address order, with
//   i_end_of_image high on its final byte. Only the final byte produces a result beat,
//   carrying o_guess_count, o_first_model and o_second_model; the next byte begins a new
//   image. i_cfg_we with i_cfg_data sets the guess limit (2 after reset); write it only
//   between images.
//   Throughput: one byte per cycle, save a final byte held back by a busy result register.
//   Each byte sits in the input register, then the scan logic folds it into the state and,
//   for a final byte, loads the result register, which drives o_out_valid; a final byte
//   waits in the input register while the result register is busy.
//   Receiver stall: the result register holds its beat; ordinary bytes keep flowing, and
//   only a final byte waits in the input register (raising o_in_stall) until the result
//   register frees up.
//   Reset (synchronous, active low): clears both registers' valid flags, the scan state
//   and sets the guess limit to 2.
module firmware_signature_classifier_unit
    import fsc_pkg::*;
#(
    parameter int STARTUP_SIZE   = STARTUP_BYTES,
    parameter int SIG_SIZE_LIMIT = SIGNATURE_SIZE_LIMIT
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_image_byte,
    input  logic       i_end_of_image,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_guess_count,
    output logic [3:0] o_first_model,
    output logic [3:0] o_second_model
);

    logic [1:0]   r_limit;
    logic         r_in_valid, n_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid, n_out_valid;
    t_result      r_result;

    logic         out_busy;
    logic         step;
    logic         load_in;
    t_scan_status status;
    t_result      result;

    // a byte that makes no result can always advance; a final byte needs a free result slot
    always_comb begin
        out_busy   = r_out_valid && i_out_stall;
        step       = r_in_valid && (!r_in_last || !out_busy);
        o_in_stall = r_in_valid && !step;
        load_in    = i_in_valid && !o_in_stall;

        if (load_in) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end

        if (step && r_in_last) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= GUESS_LIMIT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_byte <= i_image_byte;
            r_in_last <= i_end_of_image;
        end
        if (step && r_in_last) begin
            r_result <= result;
        end
    end

    fsc_scan #(
        .STARTUP_SIZE (STARTUP_SIZE)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_status (status)
    );

    fsc_decide #(
        .STARTUP_SIZE   (STARTUP_SIZE),
        .SIG_SIZE_LIMIT (SIG_SIZE_LIMIT)
    ) u_decide (
        .i_status      (status),
        .i_guess_limit (r_limit),
        .o_result      (result)
    );

    assign o_out_valid    = r_out_valid;
    assign o_guess_count  = r_result.count;
    assign o_first_model  = r_result.first;
    assign o_second_model = r_result.second;

endmodule

[hdl/fsc_checker.sv]
// Port-level checker for the firmware signature classifier, bound to the top level.
// Depends on fsc_pkg and firmware_signature_classifier_unit_assert.svh.
`include "firmware_signature_classifier_unit_assert.svh"

module fsc_checker
    import fsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_guess_count,
    input logic [3:0] o_first_model,
    input logic [3:0] o_second_model
);

    logic       out_stalled;
    logic [9:0] out_beat;
    logic       none_beat;
    logic       single_beat;
    logic       pair_beat;
    logic       first_empty;
    logic       second_empty;
    logic       pair_ok;

    assign out_stalled  = o_out_valid && i_out_stall;
    assign out_beat     = {o_guess_count, o_first_model, o_second_model};
    assign none_beat    = o_out_valid && (o_guess_count == 2'd0);
    assign single_beat  = o_out_valid && (o_guess_count == 2'd1);
    assign pair_beat    = o_out_valid && (o_guess_count == 2'd2);
    assign first_empty  = (o_first_model == MODEL_NONE);
    assign second_empty = (o_second_model == MODEL_NONE);
    assign pair_ok      = (o_first_model == MODEL_1BD) && (o_second_model == MODEL_PAIRED);

    // a stalled result beat stays put
    `FSC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stalled, o_out_valid && $stable(out_beat))

    // an unrecognized image reports no model at all
    `FSC_ASSERT_IMP(a_none_empty, i_clk, i_rst_n, none_beat, first_empty && second_empty)

    // a single guess names a model and leaves the second slot empty
    `FSC_ASSERT_IMP(a_single, i_clk, i_rst_n, single_beat, !first_empty && second_empty)

    // two guesses only come from the paired family
    `FSC_ASSERT_IMP(a_paired, i_clk, i_rst_n, pair_beat, pair_ok)

endmodule

bind firmware_signature_classifier_unit fsc_checker u_fsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_guess_count  (o_guess_count),
    .o_first_model  (o_first_model),
    .o_second_model (o_second_model)
);

[test/tb_top.sv]
// Self-checking bench for firmware_signature_classifier_unit: streams firmware images and
// compares every result beat against a scoreboard that predicts the model guesses.
// Depends on fsc_pkg (port types and constants) and the classifier RTL.
module tb_top
    import fsc_pkg::*;
();

class model_guess_board;
    logic [1:0]  limit;
    t_count      bytes_seen;
    logic [31:0] boot_word;
    logic [55:0] tail_bytes;
    t_family     family;
    logic        magic_found;
    t_sig        sig_found;
    t_result     expected_guesses[$];
    int          errors;

    function new();
        limit  = GUESS_LIMIT_RESET;
        errors = 0;
        clear_image();
    endfunction

    function void clear_image();
        bytes_seen  = '0;
        boot_word   = '0;
        tail_bytes  = '0;
        family      = FAM_NONE;
        magic_found = 1'b0;
        sig_found   = SIG_NONE;
    endfunction

    function t_family word_family(input logic [31:0] w);
        case (w)
            WORD_F9:  return FAM_F9;
            WORD_1BD: return FAM_1BD;
            WORD_C1:  return FAM_C1;
            WORD_199: return FAM_199;
            WORD_1D1: return FAM_1D1;
            default:  return FAM_NONE;
        endcase
    endfunction

    function t_model family_model(input t_family f);
        case (f)
            FAM_F9:  return MODEL_F9;
            FAM_1BD: return MODEL_1BD;
            FAM_C1:  return MODEL_C1;
            FAM_199: return MODEL_199;
            default: return MODEL_1D1;
        endcase
    endfunction

    // Fold one accepted input beat into the image state; queue a guess on the final byte.
    function void take_byte(input logic [7:0] b, input logic is_last);
        logic [63:0] win8;
        logic [31:0] win4;
        logic [31:0] magic;
        longint      start;
        t_result     r;
        win8  = {b, tail_bytes};
        win4  = win8[63:32];
        start = longint'(bytes_seen) - 3;
        if (bytes_seen == START_WORD_LAST_IDX) begin
            boot_word = win4;
            family    = word_family(win4);
        end
        if (bytes_seen > START_WORD_LAST_IDX && family != FAM_NONE) begin
            magic = (family == FAM_C1) ? MAGIC_SHORT : MAGIC_WIDE;
            if (start >= longint'(boot_word) && start + 4 < STARTUP_BYTES && win4 == magic)
                magic_found = 1'b1;
        end
        // The window that ends on the final byte never counts.
        if (bytes_seen >= START_WORD_LAST_IDX && !is_last && sig_found == SIG_NONE) begin
            if (win8 == SIGNATURE_7E)      sig_found = SIG_7E;
            else if (win8 == SIGNATURE_3F) sig_found = SIG_3F;
            else if (win8 == SIGNATURE_FE) sig_found = SIG_FE;
        end
        tail_bytes = win8[63:8];
        if (bytes_seen != COUNT_MAX)
            bytes_seen = bytes_seen + 1'b1;
        if (!is_last)
            return;
        r = '0;
        if (bytes_seen >= STARTUP_BYTES && family != FAM_NONE && magic_found) begin
            r.count = 2'd1;
            r.first = family_model(family);
            if (family == FAM_1BD && limit >= GUESS_LIMIT_PAIR) begin
                r.count  = 2'd2;
                r.second = MODEL_PAIRED;
            end
        end else if (bytes_seen > SIG_MIN_SIZE && bytes_seen <= SIGNATURE_SIZE_LIMIT &&
                     sig_found != SIG_NONE) begin
            r.count = 2'd1;
            r.first = MODEL_SIG_BASE + t_model'(sig_found);
        end
        expected_guesses.push_back(r);
        clear_image();
    endfunction

    function void check_guess(input logic [1:0] count, input t_model first,
                              input t_model second);
        t_result r;
        if (expected_guesses.size() == 0) begin
            $display("%0t: unexpected result beat count=%0d first=%0d second=%0d",
                     $time, count, first, second);
            errors++;
            return;
        end
        r = expected_guesses.pop_front();
        if (count !== r.count) begin
            $display("%0t: guess_count expected %0d actual %0d", $time, r.count, count);
            errors++;
        end
        if (first !== r.first) begin
            $display("%0t: first_model expected %0d actual %0d", $time, r.first, first);
            errors++;
        end
        if (second !== r.second) begin
            $display("%0t: second_model expected %0d actual %0d", $time, r.second, second);
            errors++;
        end
    endfunction
endclass

    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_image_byte;
    logic       i_end_of_image;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_guess_count;
    logic [3:0] o_first_model;
    logic [3:0] o_second_model;

    model_guess_board board;
    logic [7:0]       img[$];
    int unsigned      burst_left;
    bit               steady;
    int unsigned      cycles;

    firmware_signature_classifier_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_image_byte   (i_image_byte),
        .i_end_of_image (i_end_of_image),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_guess_count  (o_guess_count),
        .o_first_model  (o_first_model),
        .o_second_model (o_second_model)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver stall: switch between quiet, light, heavy and periodic stretches.
    initial begin : out_stall_gen
        int unsigned mode;
        int unsigned left;
        int unsigned phase;
        i_out_stall <= 1'b0;
        mode  = 0;
        left  = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 400);
            end
            left--;
            phase++;
            case (mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 4) != 0);
                default: i_out_stall <= ((phase % 7) < 3);
            endcase
        end
    end

    // Check every result beat taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_guess(o_guess_count, o_first_model, o_second_model);
    end

    // Present one beat and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        i_in_valid     <= 1'b1;
        i_image_byte   <= b;
        i_end_of_image <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_byte(b, is_last);
    endtask

    // Stream the image buffer in bursts, with noise on the payload during gaps.
    task automatic send_image();
        int unsigned gap;
        for (int i = 0; i < img.size(); i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap = steady ? 0 : $urandom_range(0, 5);
                if (gap != 0) begin
                    i_in_valid     <= 1'b0;
                    i_image_byte   <= 8'($urandom);
                    i_end_of_image <= 1'($urandom);
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            send_byte(img[i], i == img.size() - 1);
        end
    endtask

    task automatic build(input int n);
        img.delete();
        repeat (n) img.push_back(8'($urandom));
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // Drop len bytes of v into the image, little-endian, from address pos.
    task automatic put_bytes(input int pos, input logic [63:0] v, input int len);
        for (int k = 0; k < len; k++)
            img[pos + k] = v[8*k +: 8];
    endtask

    task automatic word_image(input int n, input logic [31:0] w, input int magic_pos,
                              input logic [31:0] magic);
        build(n);
        put_bytes(4, w, 4);
        if (magic_pos >= 0)
            put_bytes(magic_pos, magic, 4);
    endtask

    // Drop valid and wait until every expected beat has arrived, plus the pipeline depth.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.expected_guesses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [1:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.limit = v;
    endtask

    initial begin : stimulus
        int          sz;
        int          lo;
        int          pos;
        int unsigned kind;
        logic [31:0] w;
        logic [31:0] magic;
        logic [63:0] sig;
        board = new();
        burst_left = 0;
        steady     = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_image_byte   <= '0;
        i_end_of_image <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed images ---
        build(1);
        send_image();
        // Signature in the window ending on the final byte: ignored.
        build(8);
        put_bytes(0, SIGNATURE_7E, 8);
        send_image();
        build(9);
        put_bytes(0, SIGNATURE_7E, 8);
        send_image();
        build(9);
        put_bytes(1, SIGNATURE_3F, 8);
        send_image();
        build(16);
        put_bytes(5, SIGNATURE_3F, 8);
        send_image();
        build(16);
        put_bytes(3, SIGNATURE_FE, 8);
        send_image();
        // Two signatures: the first one found wins.
        build(24);
        put_bytes(2, SIGNATURE_FE, 8);
        put_bytes(10, SIGNATURE_7E, 8);
        send_image();
        // Byte extremes, nothing recognized.
        build(20);
        foreach (img[k]) img[k] = 8'hFF;
        send_image();
        build(20);
        foreach (img[k]) img[k] = 8'h00;
        send_image();
        // Magic window bounds: first allowed start, one below, last allowed, one past.
        word_image(STARTUP_BYTES, WORD_F9, int'(WORD_F9), MAGIC_WIDE);
        send_image();
        word_image(STARTUP_BYTES, WORD_F9, int'(WORD_F9) - 1, MAGIC_WIDE);
        send_image();
        word_image(STARTUP_BYTES, WORD_1BD, STARTUP_BYTES - 5, MAGIC_WIDE);
        send_image();
        word_image(STARTUP_BYTES, WORD_1BD, STARTUP_BYTES - 4, MAGIC_WIDE);
        send_image();
        word_image(STARTUP_BYTES + 3, WORD_C1, 600, MAGIC_SHORT);
        send_image();
        // Word path wins over a signature when both apply.
        word_image(STARTUP_BYTES, WORD_1D1, 700, MAGIC_WIDE);
        put_bytes(40, SIGNATURE_3F, 8);
        send_image();
        // One byte short of the startup size: fall back to the signature.
        word_image(STARTUP_BYTES - 1, WORD_1BD, 800, MAGIC_WIDE);
        put_bytes(900, SIGNATURE_7E, 8);
        send_image();
        // Guess limit below two drops the paired guess; three keeps it.
        write_limit(2'd1);
        word_image(STARTUP_BYTES, WORD_1BD, 450, MAGIC_WIDE);
        send_image();
        write_limit(2'd3);
        word_image(STARTUP_BYTES, WORD_1BD, 470, MAGIC_WIDE);
        send_image();
        write_limit(2'd2);

        // --- random images ---
        for (int n = 0; n < 32; n++) begin
            if (n % 12 == 11)
                write_limit(2'($urandom_range(0, 3)));
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    // Word image near the startup size, real or near-miss word.
                    case ($urandom_range(0, 6))
                        0:       w = WORD_F9;
                        1:       w = WORD_1BD;
                        2:       w = WORD_C1;
                        3:       w = WORD_199;
                        4:       w = WORD_1D1;
                        5:       w = WORD_1BD ^ (32'd1 << $urandom_range(0, 31));
                        default: w = $urandom;
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        sz = $urandom_range(900, STARTUP_BYTES - 1);
                    else
                        sz = STARTUP_BYTES + $urandom_range(0, 8);
                    lo = (w < 32'd900) ? int'(w) - 3 : 8;
                    magic = (w == WORD_C1) ? MAGIC_SHORT : MAGIC_WIDE;
                    if ($urandom_range(0, 4) == 0)
                        magic = (magic == MAGIC_SHORT) ? MAGIC_WIDE : MAGIC_SHORT;
                    pos = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(lo, 1021);
                    if (pos > sz - 4)
                        pos = sz - 4;
                    word_image(sz, w, pos, magic);
                    if ($urandom_range(0, 2) == 0)
                        put_bytes($urandom_range(8, sz - 9), SIGNATURE_7E, 8);
                end
                1, 2, 3, 4, 5, 6, 7: begin
                    // Signature image: one or two signatures, some with a flipped bit.
                    sz = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 300)
                                                     : $urandom_range(9, 64);
                    build(sz);
                    repeat ($urandom_range(1, 2)) begin
                        case ($urandom_range(0, 2))
                            0:       sig = SIGNATURE_7E;
                            1:       sig = SIGNATURE_3F;
                            default: sig = SIGNATURE_FE;
                        endcase
                        if ($urandom_range(0, 4) == 0)
                            sig = sig ^ (64'd1 << $urandom_range(0, 63));
                        put_bytes($urandom_range(0, sz - 8), sig, 8);
                    end
                end
                default: build($urandom_range(1, 12));
            endcase
            send_image();
        end

        // Drain and report.
        settle();
        repeat (4) @(posedge i_clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
